### rtl/adcwsa_pkg.sv
// shared widths, register indexes and controller/datapath interface types
`default_nettype none

package adcwsa_pkg;

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int CNT_W    = 5;
   // sum of up to 31 samples
   localparam int SUM_W    = SAMPLE_W + CNT_W;

   // configuration port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_COUNT = 1'b1;

   // register reset values
   localparam logic [SAMPLE_W-1:0] TOLERANCE_RST = '0;
   localparam logic [CNT_W-1:0]    REF_COUNT_RST = 5'd1;

   // default ring depth
   localparam int RING_DEPTH_DEF = 16;

   // commands from the controller to the datapath
   typedef struct packed {
      logic push;       // store a new sample
      logic start;      // begin a query
      logic walk;       // step the read pointer back
      logic acc;        // take in the sample just read
      logic div_start;  // load the divider
      logic div_step;   // one quotient bit
      logic out_load;   // load the result register
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic fail;       // count unusable or sample out of tolerance
      logic last;       // sample being taken in is the final one
      logic div_done;   // divider on its final bit
      logic rsp_busy;   // result register full and not taken this cycle
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/adcwsa_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module adcwsa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/adcwsa_ctrl.sv
// controller state machine sequencing push, walk, divide and result
`default_nettype none

module adcwsa_ctrl
   import adcwsa_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_op,
   output logic              req_ready,
   output dp_cmd_type        cmd,
   input  wire dp_stat_type  stat
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WAIT   = 3'd1;
   localparam logic [2:0] S_ACC    = 3'd2;
   localparam logic [2:0] S_DSTART = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op) begin
                  cmd.start = 1'b1;
                  state_in  = S_WAIT;
               end else begin
                  cmd.push = 1'b1;
               end
            end
         end
         S_WAIT: begin
            // first read in flight; skip the walk for an unusable count
            if (stat.fail) begin
               state_in = S_OUT;
            end else begin
               cmd.walk = 1'b1;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.walk = 1'b1;
            cmd.acc  = 1'b1;
            if (stat.last) begin
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

### rtl/adcwsa_dp.sv
// datapath: sample ring, config registers, tolerance check, sum, divider, result
`default_nettype none

module adcwsa_dp
   import adcwsa_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [SAMPLE_W-1:0]   req_sample,
   input  wire                  csr_valid,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [SAMPLE_W-1:0]   csr_wdata,
   input  wire                  rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_valid_res,
   output logic [SAMPLE_W-1:0]  rsp_average,
   input  wire dp_cmd_type      cmd,
   output dp_stat_type          stat
);

   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int STEP_W = $clog2(SUM_W);

   // configuration registers
   logic [SAMPLE_W-1:0] tol_ff;
   logic [CNT_W-1:0]    cnt_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= TOLERANCE_RST;
         cnt_lim_ff <= REF_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TOLERANCE: tol_ff     <= csr_wdata;
            CSR_REF_COUNT: cnt_lim_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // newest index and write side of the ring
   logic [IDX_W-1:0]      newest_ff;
   logic [IDX_W-1:0]      newest_in;
   logic [RING_DEPTH-1:0] vld_ff;

   assign newest_in = (newest_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : newest_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
         vld_ff    <= '0;
      end else if (cmd.push) begin
         newest_ff         <= newest_in;
         vld_ff[newest_in] <= 1'b1;
      end
   end

   // read pointer walking backwards
   logic [IDX_W-1:0]    pos_ff;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic                rd_vld_ff;
   logic [SAMPLE_W-1:0] smp;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pos_ff <= newest_ff;
      end else if (cmd.walk) begin
         pos_ff <= (pos_ff == '0) ? IDX_W'(RING_DEPTH - 1) : pos_ff - 1'b1;
      end
      rd_vld_ff <= vld_ff[pos_ff];
   end

   adcwsa_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (newest_in),
      .wr_data (req_sample),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // entries never written read as zero
   assign smp = rd_vld_ff ? ram_rd_data : '0;

   // tolerance check and running sum
   logic [SAMPLE_W-1:0] ref_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                fail_ff;
   logic                cnt_bad;
   logic [SAMPLE_W-1:0] diff;

   assign cnt_bad = (cnt_lim_ff == '0) || (32'(cnt_lim_ff) > RING_DEPTH);
   assign diff    = (smp > ref_ff) ? smp - ref_ff : ref_ff - smp;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         fail_ff <= cnt_bad;
      end else if (cmd.acc) begin
         sum_ff <= sum_ff + SUM_W'(smp);
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == '0) begin
            ref_ff <= smp;
         end else if (diff > tol_ff) begin
            fail_ff <= 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [CNT_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, cnt_lim_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff  <= '0;
         quo_ff  <= sum_ff;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? CNT_W'(trial - {1'b0, cnt_lim_ff}) : CNT_W'(trial);
         quo_ff  <= {quo_ff[SUM_W-2:0], ge};
         step_ff <= step_ff + 1'b1;
      end
   end

   // result register
   logic                rsp_valid_ff;
   logic                rsp_res_ff;
   logic [SAMPLE_W-1:0] rsp_avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_res_ff <= !fail_ff;
         rsp_avg_ff <= fail_ff ? '0 : quo_ff[SAMPLE_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;
   assign rsp_average   = rsp_avg_ff;

   // status to the controller
   assign stat.fail     = fail_ff;
   assign stat.last     = (cnt_ff + 1'b1) == cnt_lim_ff;
   assign stat.div_done = step_ff == STEP_W'(SUM_W - 1);
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

### rtl/adc_window_stable_average.sv
// top level: stable-window average over a ring of converter samples
// push item: taken while idle, input stays ready, no result
// query item: result follows one ring read per checked sample plus a bit-serial divider
// one query at a time; a query with an unusable count skips the walk and the divider
// reset: synchronous, clears ring valid bits, newest index, registers, result
`default_nettype none

module adc_window_stable_average
   import adcwsa_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire                  req_op,
   input  wire [SAMPLE_W-1:0]   req_sample,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic                 rsp_valid_res,
   output logic [SAMPLE_W-1:0]  rsp_average,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [SAMPLE_W-1:0]   csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // registers always accept a write
   assign csr_ready = 1'b1;

   adcwsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   adcwsa_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_sample    (req_sample),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_valid_res (rsp_valid_res),
      .rsp_average   (rsp_average),
      .cmd           (cmd),
      .stat          (stat)
   );

`ifndef SYNTHESIS
   // a query item closes the input until its result is loaded
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op) |=> !req_ready)
      else $error("input ready after query item");

   // a failed query reports a zero average
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_average == '0))
      else $error("nonzero average on invalid result");

   // a push item never produces a result
   a_push_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_op && !rsp_valid) |=> !rsp_valid)
      else $error("result after push item");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

### test/adc_window_stable_average_test.sv
// testbench for the stable-window average block: directed and random items, self-checking
`timescale 1ns / 100ps

module adc_window_stable_average_test;
   import adcwsa_pkg::*;

   localparam int RING_DEPTH     = RING_DEPTH_DEF;
   localparam logic OP_PUSH      = 1'b0;
   localparam logic OP_QUERY     = 1'b1;
   // settle wait covers the longest query with margin
   localparam int SETTLE_CYCLES  = 48;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   // receiver stall patterns
   localparam int READY_ALWAYS   = 0;
   localparam int READY_HALF     = 1;
   localparam int READY_SPARSE   = 2;

   typedef struct packed {
      logic                valid_res;
      logic [SAMPLE_W-1:0] average;
   } avg_result_type;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_op      = OP_PUSH;
   logic [SAMPLE_W-1:0]  req_sample  = '0;
   logic                 rsp_ready   = 1'b0;
   logic                 csr_valid   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_TOLERANCE;
   logic [SAMPLE_W-1:0]  csr_wdata   = '0;
   wire                  req_ready;
   wire                  rsp_valid;
   wire                  rsp_valid_res;
   wire [SAMPLE_W-1:0]   rsp_average;
   wire                  csr_ready;

   // shadow copy of the block state and registers
   logic [SAMPLE_W-1:0]  shadow_ring [RING_DEPTH];
   int                   shadow_newest;
   logic [SAMPLE_W-1:0]  shadow_tolerance;
   logic [CNT_W-1:0]     shadow_count;

   avg_result_type       pending_averages [$];
   avg_result_type       checked_entry;

   int                   error_count  = 0;
   int                   push_count   = 0;
   int                   query_count  = 0;
   int                   stable_count = 0;
   int                   quiet_cycles = 0;

   // sender burst control
   bit                   gaps_on    = 1'b1;
   int                   burst_left = 0;

   // receiver stall control
   int                   hold_asks  = 0;
   int                   hold_seen  = 0;
   int                   hold_left  = 0;
   int                   rsp_mode   = READY_ALWAYS;
   int                   mode_left  = 0;

   adc_window_stable_average #(
      .RING_DEPTH (RING_DEPTH)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res),
      .rsp_average   (rsp_average),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // expected outcome of a query against the shadow ring
   function automatic avg_result_type stable_average();
      avg_result_type      r;
      logic [SAMPLE_W-1:0] anchor;
      logic [SAMPLE_W-1:0] s;
      logic [SAMPLE_W-1:0] dev;
      int unsigned         sum;
      int                  pos;
      r = '0;
      if (shadow_count == 0 || shadow_count > RING_DEPTH) return r;
      anchor = shadow_ring[shadow_newest];
      sum = 0;
      for (int k = 0; k < shadow_count; k++) begin
         pos = (shadow_newest + RING_DEPTH - k) % RING_DEPTH;
         s = shadow_ring[pos];
         dev = (s > anchor) ? s - anchor : anchor - s;
         if (dev > shadow_tolerance) return r;
         sum += s;
      end
      r.valid_res = 1'b1;
      r.average   = SAMPLE_W'(sum / shadow_count);
      return r;
   endfunction

   // offer one item, wait for it to be taken, update the shadow state
   task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] smp);
      req_valid  <= 1'b1;
      req_op     <= op;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      if (op == OP_PUSH) begin
         shadow_newest = (shadow_newest + 1) % RING_DEPTH;
         shadow_ring[shadow_newest] = smp;
         push_count++;
      end else begin
         pending_averages.push_back(stable_average());
         query_count++;
      end
      // end of burst: drop valid for a random gap
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   // block idle: every answer back and any trailing work finished
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers back to back
   task automatic set_config(input logic [SAMPLE_W-1:0] tol, input logic [CNT_W-1:0] cnt);
      csr_valid <= 1'b1;
      csr_index <= CSR_TOLERANCE;
      csr_wdata <= tol;
      do @(posedge clock); while (!csr_ready);
      shadow_tolerance = tol;
      csr_index <= CSR_REF_COUNT;
      csr_wdata <= SAMPLE_W'(cnt);
      do @(posedge clock); while (!csr_ready);
      shadow_count = cnt;
      csr_valid <= 1'b0;
   endtask

   // ring contents straight after reset
   task automatic test_reset_contents();
      send_item(OP_QUERY, 10'h000);
      wait_for_quiet();
      set_config(10'd0, 5'd16);
      send_item(OP_QUERY, 10'h3FF);
   endtask

   // sample extremes, zero count and counts beyond the ring
   task automatic test_limits_and_counts();
      send_item(OP_PUSH, 10'h3FF);
      send_item(OP_PUSH, 10'h000);
      wait_for_quiet();
      set_config(10'h3FF, 5'd2);
      send_item(OP_QUERY, 10'h155);
      wait_for_quiet();
      set_config(10'h3FF, 5'd0);
      send_item(OP_QUERY, 10'h2AA);
      wait_for_quiet();
      set_config(10'h3FF, 5'd17);
      send_item(OP_QUERY, 10'h000);
      wait_for_quiet();
      set_config(10'h3FF, 5'd31);
      send_item(OP_QUERY, 10'h3FF);
      send_item(OP_PUSH, 10'h155);
      send_item(OP_PUSH, 10'h2AA);
      wait_for_quiet();
      set_config(10'd0, 5'd1);
      send_item(OP_QUERY, 10'h000);
   endtask

   // deviation exactly at the tolerance passes, one beyond fails
   task automatic test_tolerance_edge();
      wait_for_quiet();
      set_config(10'd5, 5'd3);
      send_item(OP_PUSH, 10'd500);
      send_item(OP_PUSH, 10'd505);
      send_item(OP_PUSH, 10'd500);
      send_item(OP_QUERY, 10'd0);
      send_item(OP_PUSH, 10'd506);
      send_item(OP_QUERY, 10'd0);
   endtask

   // one setting: pushes clustered round a wandering level, queries between
   task automatic run_window(input logic [SAMPLE_W-1:0] tol, input logic [CNT_W-1:0] cnt,
                             input int n);
      int level;
      int spread;
      int v;
      wait_for_quiet();
      set_config(tol, cnt);
      level  = $urandom_range(0, 1023);
      spread = ($urandom_range(0, 3) == 0) ? tol / 2 + 2 : tol / 2;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 25) begin
            send_item(OP_QUERY, SAMPLE_W'($urandom));
         end else if ($urandom_range(0, 99) < 6) begin
            send_item(OP_PUSH, SAMPLE_W'($urandom));
         end else begin
            if ($urandom_range(0, 39) == 0) level = $urandom_range(0, 1023);
            v = level + $urandom_range(0, 2 * spread) - spread;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            send_item(OP_PUSH, SAMPLE_W'(v));
         end
      end
   endtask

   task automatic test_random_windows();
      int tol;
      int cnt;
      run_window(10'd0, 5'd1, 130);
      run_window(10'h3FF, 5'd16, 130);
      run_window(10'd0, 5'd16, 130);
      run_window(10'h3FF, 5'd0, 40);
      run_window(10'h3FF, 5'd17, 40);
      run_window(10'h3FF, 5'd31, 40);
      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(0, 19))
            0, 1, 2:       tol = $urandom_range(0, 1023);
            3, 4, 5, 6, 7: tol = $urandom_range(16, 200);
            default:       tol = $urandom_range(0, 15);
         endcase
         cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
         run_window(SAMPLE_W'(tol), CNT_W'(cnt), 130);
      end
   endtask

   // receiver holds off for a long stretch while items keep coming
   task automatic test_backpressure();
      wait_for_quiet();
      set_config(10'h3FF, 5'd16);
      gaps_on = 1'b0;
      hold_asks <= hold_asks + 1;
      for (int i = 0; i < 80; i++) begin
         if ($urandom_range(0, 9) < 3) send_item(OP_QUERY, SAMPLE_W'($urandom));
         else send_item(OP_PUSH, SAMPLE_W'($urandom));
      end
      gaps_on = 1'b1;
   endtask

   // result checking and receiver stall pattern
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (pending_averages.size() == 0) begin
            $error("result with no query outstanding: valid_res %0d, average %0d",
                   rsp_valid_res, rsp_average);
            error_count++;
         end else begin
            checked_entry = pending_averages.pop_front();
            if (rsp_valid_res !== checked_entry.valid_res) begin
               $error("valid_res: expected %0d, got %0d", checked_entry.valid_res,
                      rsp_valid_res);
               error_count++;
            end
            if (rsp_average !== checked_entry.average) begin
               $error("average: expected %0d, got %0d", checked_entry.average, rsp_average);
               error_count++;
            end
            if (checked_entry.valid_res) stable_count++;
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rsp_mode  <= $urandom_range(0, 2);
            mode_left <= $urandom_range(4, 64);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rsp_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_HALF:   rsp_ready <= ($urandom_range(0, 1) == 1);
            default:      rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog on cycles with no item moving anywhere
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("adc_window_stable_average_test failed");
         $finish;
      end
   end

   // main sequence
   initial begin
      for (int i = 0; i < RING_DEPTH; i++) shadow_ring[i] = '0;
      shadow_newest    = 0;
      shadow_tolerance = TOLERANCE_RST;
      shadow_count     = REF_COUNT_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_contents();
      test_limits_and_counts();
      test_tolerance_edge();
      test_random_windows();
      test_backpressure();
      wait_for_quiet();
      $display("covered %0d pushes and %0d queries, %0d of them stable",
               push_count, query_count, stable_count);
      $display("also zero and oversized counts, full-ring windows, tolerance edges, long stall");
      if (error_count == 0)
         $display("adc_window_stable_average_test passed");
      else
         $display("adc_window_stable_average_test failed");
      $finish;
   end

endmodule
